### hw/rtl/prefix_edit_distance_check_defines.svh
// Assertion macros used by the prefix edit distance check top level.
`ifndef PREFIX_EDIT_DISTANCE_CHECK_DEFINES_SVH
`define PREFIX_EDIT_DISTANCE_CHECK_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PEDC_AST_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PEDC_AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/pedc_pkg.sv
// Shared types and constants of the prefix edit distance check.
package pedc_pkg;

	localparam int CHAR_W     = 16;
	localparam int DIST_W     = 6;
	localparam int DIST_MAX   = 63;
	localparam int MIN_LIMIT  = 3;
	// floor(n / 3) == (n * 171) >> 9 for every n below 256.
	localparam int DIV3_MUL   = 171;
	localparam int DIV3_SHIFT = 9;

	typedef struct packed {
		logic load;     // a character pair transaction is taken
		logic start;    // the taken pair is the last one
		logic step;     // compute one anti-diagonal
		logic capture;  // register the result
	} pedc_cmd_t;

	typedef struct packed {
		logic last_step;
		logic no_steps;
	} pedc_stat_t;

endpackage

### hw/rtl/pedc_dp.sv
// Datapath: word stores, anti-diagonal cell row and result registers.
module pedc_dp import pedc_pkg::*; #(
	parameter int MAX_LEN   = 32,
	parameter int CHAR_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pedc_cmd_t         cmd,
	input  logic [CHAR_W-1:0] char_a,
	input  logic              has_a,
	input  logic [CHAR_W-1:0] char_b,
	input  logic              has_b,
	output pedc_stat_t        stat,
	output logic              similar,
	output logic [DIST_W-1:0] distance,
	output logic              too_long
);

	localparam int STORE_W = (CHAR_BITS < CHAR_W) ? CHAR_BITS : CHAR_W;
	localparam int LW      = $clog2(MAX_LEN + 1);
	localparam int IW      = $clog2(MAX_LEN);
	localparam int KW      = LW + 1;
	localparam int PW      = LW + 8;

	logic [LW-1:0]      len_a_q, len_b_q;
	logic               end_a_q, end_b_q, cut_q;
	logic [KW-1:0]      k_q;
	logic [STORE_W-1:0] fw_q [MAX_LEN];
	logic [STORE_W-1:0] sw_q [MAX_LEN];
	logic [STORE_W-1:0] fa_q [MAX_LEN];
	logic [LW-1:0]      d1_q [MAX_LEN];
	logic [LW-1:0]      d2_q [MAX_LEN];
	logic [LW-1:0]      cell_new [MAX_LEN];

	logic               full_a, full_b, put_a, put_b;
	logic [LW-1:0]      len_m;
	logic [KW-1:0]      total;
	logic [LW-1:0]      dist_full;
	logic [PW-1:0]      prod;
	logic [LW-1:0]      lim_raw, limit;

	logic               similar_q, too_long_q;
	logic [DIST_W-1:0]  distance_q;

	assign full_a = (len_a_q == LW'(MAX_LEN));
	assign full_b = (len_b_q == LW'(MAX_LEN));
	assign put_a  = cmd.load && !end_a_q && has_a && !full_a;
	assign put_b  = cmd.load && !end_b_q && has_b && !full_b;

	// The second word is cut to the length of the first.
	assign len_m = (len_b_q < len_a_q) ? len_b_q : len_a_q;
	assign total = KW'(len_a_q) + KW'(len_m);

	assign stat.last_step = (k_q == total);
	assign stat.no_steps  = (total == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_a_q <= '0;
			len_b_q <= '0;
			end_a_q <= 1'b0;
			end_b_q <= 1'b0;
			cut_q   <= 1'b0;
			k_q     <= '0;
		end else begin
			if (cmd.capture) begin
				len_a_q <= '0;
				len_b_q <= '0;
				end_a_q <= 1'b0;
				end_b_q <= 1'b0;
				cut_q   <= 1'b0;
			end else if (cmd.load) begin
				if (!end_a_q) begin
					if (!has_a) begin
						end_a_q <= 1'b1;
					end else if (full_a) begin
						cut_q <= 1'b1;
					end else begin
						len_a_q <= len_a_q + LW'(1);
					end
				end
				if (!end_b_q) begin
					if (!has_b) begin
						end_b_q <= 1'b1;
					end else if (full_b) begin
						cut_q <= 1'b1;
					end else begin
						len_b_q <= len_b_q + LW'(1);
					end
				end
			end
			if (cmd.start) begin
				k_q <= KW'(1);
			end else if (cmd.step) begin
				k_q <= k_q + KW'(1);
			end
		end
	end

	// Cell c holds column j = c + 1. On diagonal k it computes row i = k - j,
	// reading the two previous diagonals. The first word streams through fa_q
	// so that every cell sees its own character at a fixed place.
	for (genvar c = 0; c < MAX_LEN; c++) begin : g_cell
		logic [LW-1:0] left1, left2;
		logic [LW:0]   s_up, s_left, s_diag, m1, mn;
		logic          cost, top;

		if (c == 0) begin : g_edge
			assign left1 = LW'(k_q - KW'(1));
			assign left2 = LW'(k_q - KW'(2));
		end else begin : g_inner
			assign left1 = d1_q[c-1];
			assign left2 = d2_q[c-1];
		end

		assign cost   = (fa_q[c] != sw_q[c]);
		assign top    = (k_q == KW'(c + 1));
		assign s_up   = {1'b0, d1_q[c]} + (LW+1)'(1);
		assign s_left = {1'b0, left1} + (LW+1)'(1);
		assign s_diag = {1'b0, left2} + (LW+1)'(cost);
		assign m1     = (s_up < s_left) ? s_up : s_left;
		assign mn     = (m1 < s_diag) ? m1 : s_diag;
		assign cell_new[c] = top ? LW'(c + 1) : mn[LW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			if (put_a) begin
				fw_q[len_a_q[IW-1:0]] <= char_a[STORE_W-1:0];
			end
			if (put_b) begin
				sw_q[len_b_q[IW-1:0]] <= char_b[STORE_W-1:0];
			end
		end else if (cmd.step) begin
			fa_q[0] <= fw_q[0];
			for (int c = 1; c < MAX_LEN; c++) begin
				fa_q[c] <= fa_q[c-1];
			end
			for (int c = 0; c < MAX_LEN - 1; c++) begin
				fw_q[c] <= fw_q[c+1];
			end
			for (int c = 0; c < MAX_LEN; c++) begin
				d1_q[c] <= cell_new[c];
				d2_q[c] <= d1_q[c];
			end
		end
	end

	// With an empty second word the distance is the first word's length.
	assign dist_full = (len_m == '0) ? len_a_q : d1_q[IW'(len_m - LW'(1))];
	assign prod      = PW'(len_a_q) * PW'(DIV3_MUL);
	assign lim_raw   = LW'(prod >> DIV3_SHIFT);
	assign limit     = (lim_raw < LW'(MIN_LIMIT)) ? LW'(MIN_LIMIT) : lim_raw;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			similar_q  <= (dist_full <= limit);
			too_long_q <= cut_q;
			if (32'(dist_full) > DIST_MAX) begin
				distance_q <= DIST_W'(DIST_MAX);
			end else begin
				distance_q <= DIST_W'(dist_full);
			end
		end
	end

	assign similar  = similar_q;
	assign distance = distance_q;
	assign too_long = too_long_q;

endmodule

### hw/rtl/pedc_ctrl.sv
// Controller: load, compute and finish sequencing with the output handshake.
module pedc_ctrl import pedc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  logic       last_pair,
	input  logic       result_stall,
	input  pedc_stat_t stat,
	output logic       item_stall,
	output logic       result_valid,
	output pedc_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_LOAD,
		S_CALC,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   result_valid_q;

	always_comb begin
		cmd         = '0;
		cmd.load    = (state_q == S_LOAD) && item_valid;
		cmd.start   = cmd.load && last_pair;
		cmd.step    = (state_q == S_CALC) && !stat.no_steps;
		// The result register is written only when it is empty or being taken.
		cmd.capture = (state_q == S_FINISH) && (!result_valid_q || !result_stall);
	end

	assign item_stall   = (state_q != S_LOAD);
	assign result_valid = result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_LOAD;
			result_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_LOAD: begin
					if (cmd.start) begin
						state_q <= S_CALC;
					end
				end
				S_CALC: begin
					if (stat.no_steps || stat.last_step) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (cmd.capture) begin
						state_q <= S_LOAD;
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
			if (cmd.capture) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

endmodule

### hw/rtl/prefix_edit_distance_check.sv
// Load one character pair per cycle while item_stall is low; when the last pair arrives,
// the word pair is scored on a row of MAX_LEN cells, one anti-diagonal of the distance
// table per cycle, over n + m anti-diagonals (n, m: the first word's length and the cut
// second word's length; none when the first word is empty). The result is then captured
// once the output register is free. The next word pair loads while a result waits.
// Reset clears the sequencer, lengths and flags; the word stores are not cleared.
`include "prefix_edit_distance_check_defines.svh"

module prefix_edit_distance_check import pedc_pkg::*; #(
	parameter int MAX_LEN   = 32,
	parameter int CHAR_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [CHAR_W-1:0] char_a,
	input  logic              has_a,
	input  logic [CHAR_W-1:0] char_b,
	input  logic              has_b,
	input  logic              last_pair,
	output logic              result_valid,
	input  logic              result_stall,
	output logic              similar,
	output logic [DIST_W-1:0] distance,
	output logic              too_long
);

	pedc_cmd_t  cmd;
	pedc_stat_t stat;

	pedc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.last_pair    (last_pair),
		.result_stall (result_stall),
		.stat         (stat),
		.item_stall   (item_stall),
		.result_valid (result_valid),
		.cmd          (cmd)
	);

	pedc_dp #(
		.MAX_LEN   (MAX_LEN),
		.CHAR_BITS (CHAR_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.char_a   (char_a),
		.has_a    (has_a),
		.char_b   (char_b),
		.has_b    (has_b),
		.stat     (stat),
		.similar  (similar),
		.distance (distance),
		.too_long (too_long)
	);

	`PEDC_AST_NOW(a_no_overwrite, cmd.capture, !result_valid || !result_stall, "result overwritten")
	`PEDC_AST_NEXT(a_capture_shows, cmd.capture, result_valid, "captured result not presented")
	`PEDC_AST_NOW(a_no_load_in_calc, cmd.step, item_stall && !cmd.load, "transaction taken during compute")
	`PEDC_AST_NOW(a_small_is_similar, result_valid && (distance <= 6'd3), similar, "threshold floor broken")

endmodule

### tb/prefix_edit_distance_check_test.sv
// Self-checking testbench for the prefix edit distance check block.
`timescale 1ns / 100ps

module prefix_edit_distance_check_test import pedc_pkg::*;;

	localparam int MAX_LEN      = 32;
	localparam int CHAR_BITS    = 16;
	localparam int RANDOM_ITEMS = 1750;
	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 2 * MAX_LEN + 16;
	localparam int REPORT_MAX   = 10;
	localparam logic [CHAR_W-1:0] CHAR_MASK = CHAR_W'((64'd1 << CHAR_BITS) - 1);

	typedef struct packed {
		logic [CHAR_W-1:0] ca;
		logic              ha;
		logic [CHAR_W-1:0] cb;
		logic              hb;
		logic              lp;
	} pair_item_t;

	typedef struct packed {
		logic              similar;
		logic [DIST_W-1:0] edit_count;
		logic              cut;
	} score_t;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              item_valid   = 1'b0;
	logic              item_stall;
	logic [CHAR_W-1:0] char_a       = '0;
	logic              has_a        = 1'b0;
	logic [CHAR_W-1:0] char_b       = '0;
	logic              has_b        = 1'b0;
	logic              last_pair    = 1'b0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic              similar;
	logic [DIST_W-1:0] distance;
	logic              too_long;

	// Stimulus and expected scores.
	pair_item_t        char_pairs[$];
	score_t            awaited_scores[$];
	logic [CHAR_W-1:0] typed_word[$];
	logic [CHAR_W-1:0] predicted_word[$];
	int                built_items = 0;

	// Predictor state: index 0 is the typed word, index 1 the predicted word.
	logic [CHAR_W-1:0] word_chars [2][MAX_LEN];
	int                word_len [2] = '{0, 0};
	bit                word_done [2] = '{1'b0, 1'b0};
	bit                cut_seen = 1'b0;

	int scored_pairs  = 0;
	int similar_pairs = 0;
	int cut_pairs     = 0;
	int sent_items    = 0;
	int checked       = 0;
	int mismatch_count = 0;
	int idle_cycles   = 0;

	// Idle pattern state of both sides.
	int         send_wait   = 0;
	int         send_run    = 0;
	bit         send_quiet  = 1'b0;
	int         hold_left   = 0;
	int         recv_run    = 0;
	bit         recv_quiet  = 1'b0;
	bit         slot_free;
	pair_item_t next_pair;

	prefix_edit_distance_check #(
		.MAX_LEN  (MAX_LEN),
		.CHAR_BITS(CHAR_BITS)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.char_a      (char_a),
		.has_a       (has_a),
		.char_b      (char_b),
		.has_b       (has_b),
		.last_pair   (last_pair),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.similar     (similar),
		.distance    (distance),
		.too_long    (too_long)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int pick_idle(input bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 40);
	endfunction

	function automatic int edit_distance(input int n, input int m);
		int row [0:MAX_LEN];
		int diag, up, cost, best;
		for (int j = 0; j <= m; j++)
			row[j] = j;
		for (int i = 0; i < n; i++) begin
			diag = row[0];
			row[0] = i + 1;
			for (int j = 0; j < m; j++) begin
				up = row[j + 1];
				cost = (word_chars[0][i] == word_chars[1][j]) ? 0 : 1;
				best = up + 1;
				if (row[j] + 1 < best)
					best = row[j] + 1;
				if (diag + cost < best)
					best = diag + cost;
				row[j + 1] = best;
				diag = up;
			end
		end
		return row[m];
	endfunction

	// Absorbs one accepted character pair; a final pair yields one score.
	task automatic score_pair(input pair_item_t it);
		logic [CHAR_W-1:0] unit [2];
		bit                present [2];
		int                n, m, d, lim;
		score_t            s;
		unit[0] = it.ca & CHAR_MASK;
		unit[1] = it.cb & CHAR_MASK;
		present[0] = it.ha;
		present[1] = it.hb;
		for (int w = 0; w < 2; w++) begin
			if (!word_done[w]) begin
				if (!present[w])
					word_done[w] = 1'b1;
				else if (word_len[w] >= MAX_LEN)
					cut_seen = 1'b1;
				else begin
					word_chars[w][word_len[w]] = unit[w];
					word_len[w]++;
				end
			end
		end
		if (it.lp) begin
			n = word_len[0];
			m = (word_len[1] < n) ? word_len[1] : n;
			d = edit_distance(n, m);
			lim = n / 3;
			if (lim < MIN_LIMIT)
				lim = MIN_LIMIT;
			s.similar = (d <= lim);
			s.edit_count = (d > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(d);
			s.cut = cut_seen;
			awaited_scores.push_back(s);
			scored_pairs++;
			similar_pairs += s.similar;
			cut_pairs += s.cut;
			word_len = '{0, 0};
			word_done = '{1'b0, 1'b0};
			cut_seen = 1'b0;
		end
	endtask

	// One code unit of a word at position k; past the end, junk may follow the end marker.
	function automatic void word_unit(input int k, input int len, input logic [CHAR_W-1:0] ch_in,
			input bit junk, output logic [CHAR_W-1:0] ch, output logic present);
		if (k < len) begin
			ch = ch_in;
			present = 1'b1;
		end else begin
			ch = CHAR_W'($urandom);
			present = (k > len && junk) ? 1'($urandom) : 1'b0;
		end
	endfunction

	// Turns the typed and predicted words into a run of character pair transactions.
	task automatic emit_word_pair(input int tail, input bit junk);
		int         total, la, lb;
		pair_item_t it;
		la = typed_word.size();
		lb = predicted_word.size();
		total = ((la > lb) ? la : lb) + tail;
		if (total == 0)
			total = 1;
		for (int k = 0; k < total; k++) begin
			word_unit(k, la, (k < la) ? typed_word[k] : '0, junk, it.ca, it.ha);
			word_unit(k, lb, (k < lb) ? predicted_word[k] : '0, junk, it.cb, it.hb);
			it.lp = (k == total - 1);
			char_pairs.push_back(it);
		end
		built_items += total;
	endtask

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("MISMATCH at %0t: %s", $realtime, what);
	endtask

	// Driver: presents queued pairs, with random gaps after each accepted one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			send_wait = 0;
		end else begin
			slot_free = !item_valid;
			if (item_valid && !item_stall) begin
				score_pair('{char_a, has_a, char_b, has_b, last_pair});
				sent_items++;
				if (send_run == 0) begin
					send_run = $urandom_range(20, 150);
					send_quiet = ($urandom_range(0, 2) == 0);
				end else
					send_run--;
				send_wait = pick_idle(send_quiet);
				slot_free = 1'b1;
			end
			if (slot_free) begin
				if (send_wait == 0 && char_pairs.size() != 0) begin
					next_pair = char_pairs.pop_front();
					item_valid <= 1'b1;
					char_a <= next_pair.ca;
					has_a <= next_pair.ha;
					char_b <= next_pair.cb;
					has_b <= next_pair.hb;
					last_pair <= next_pair.lp;
				end else begin
					item_valid <= 1'b0;
					if (send_wait != 0)
						send_wait--;
				end
			end
		end
	end

	// Receiver: random back-pressure and the check of every result transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_left = 0;
		end else begin
			if (result_valid && !result_stall) begin
				checked++;
				if (awaited_scores.size() == 0)
					report_mismatch($sformatf("unexpected result similar=%0b distance=%0d too_long=%0b",
						similar, distance, too_long));
				else begin
					score_t want;
					want = awaited_scores.pop_front();
					if (similar !== want.similar || distance !== want.edit_count ||
							too_long !== want.cut)
						report_mismatch($sformatf(
							"result %0d expected %0b/%0d/%0b got %0b/%0d/%0b (similar/distance/too_long)",
							checked, want.similar, want.edit_count, want.cut, similar, distance,
							too_long));
				end
			end
			if (recv_run == 0) begin
				recv_run = $urandom_range(30, 300);
				recv_quiet = ($urandom_range(0, 2) == 0);
			end else
				recv_run--;
			if (hold_left != 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else begin
				hold_left = pick_idle(recv_quiet);
				if (hold_left != 0) begin
					hold_left--;
					result_stall <= 1'b1;
				end else
					result_stall <= 1'b0;
			end
		end
	end

	// Watchdog on cycles in which neither channel moves a transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((item_valid && !item_stall) || (result_valid && !result_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		logic [CHAR_W-1:0] letters [4];
		int kind, la, lb, edits, idx, op, extra;

		// Directed part: empty words, extreme code units, words that stop early,
		// junk after the end of a word, and a second word shorter than the first.
		emit_word_pair(0, 1'b0);
		typed_word = '{16'h0000, 16'hFFFF};
		predicted_word = '{16'hFFFF, 16'h0000};
		emit_word_pair(0, 1'b0);
		typed_word = '{16'h0041, 16'h0042, 16'h0043};
		predicted_word = '{16'h0041, 16'h0042, 16'h0043};
		emit_word_pair(0, 1'b0);
		typed_word = '{16'h0041, 16'h0042};
		predicted_word = '{16'h0041, 16'h0043, 16'h0044, 16'h0045};
		emit_word_pair(2, 1'b1);
		typed_word = '{16'h8000, 16'h7FFF, 16'h5555, 16'hAAAA, 16'h0001};
		predicted_word = '{16'h1234};
		emit_word_pair(0, 1'b0);
		typed_word.delete();
		predicted_word = '{16'h0061, 16'h0062, 16'h0063};
		emit_word_pair(0, 1'b0);

		// Random part: mostly near-miss word pairs over a small alphabet.
		while (built_items < RANDOM_ITEMS) begin
			typed_word.delete();
			predicted_word.delete();
			for (int i = 0; i < 4; i++)
				letters[i] = CHAR_W'($urandom);
			if ($urandom_range(0, 5) == 0)
				letters[0] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
			kind = $urandom_range(0, 99);
			if (kind < 9 || scored_pairs % 15 == 14) begin
				// Overlong words: one or both exceed the store and get cut.
				op = $urandom_range(0, 2);
				la = (op != 1) ? $urandom_range(MAX_LEN + 1, MAX_LEN + 8) : $urandom_range(0, MAX_LEN);
				lb = (op != 0) ? $urandom_range(MAX_LEN + 1, MAX_LEN + 8) : $urandom_range(0, MAX_LEN);
				for (int i = 0; i < la; i++)
					typed_word.push_back(letters[$urandom_range(0, 3)]);
				for (int i = 0; i < lb; i++)
					predicted_word.push_back((i < la && $urandom_range(0, 3) != 0) ?
						typed_word[i] : letters[$urandom_range(0, 3)]);
				emit_word_pair($urandom_range(0, 2), 1'($urandom));
			end else if (kind < 20) begin
				// Noise: unrelated words of random code units with junk after the end.
				la = $urandom_range(0, 8);
				lb = $urandom_range(0, 8);
				for (int i = 0; i < la; i++)
					typed_word.push_back(CHAR_W'($urandom));
				for (int i = 0; i < lb; i++)
					predicted_word.push_back(CHAR_W'($urandom));
				emit_word_pair($urandom_range(0, 3), 1'b1);
			end else begin
				la = ($urandom_range(0, 9) == 0) ? $urandom_range(13, MAX_LEN) : $urandom_range(0, 12);
				for (int i = 0; i < la; i++)
					typed_word.push_back(letters[$urandom_range(0, 3)]);
				predicted_word = typed_word;
				edits = $urandom_range(0, 6);
				for (int e = 0; e < edits; e++) begin
					op = $urandom_range(0, 2);
					if (predicted_word.size() == 0 || op == 0) begin
						idx = $urandom_range(0, predicted_word.size());
						predicted_word.insert(idx, letters[$urandom_range(0, 3)]);
					end else if (op == 1) begin
						idx = $urandom_range(0, predicted_word.size() - 1);
						predicted_word[idx] = letters[$urandom_range(0, 3)];
					end else begin
						idx = $urandom_range(0, predicted_word.size() - 1);
						predicted_word.delete(idx);
					end
				end
				extra = $urandom_range(0, 3);
				for (int i = 0; i < extra && predicted_word.size() < MAX_LEN; i++)
					predicted_word.push_back(letters[$urandom_range(0, 3)]);
				emit_word_pair(($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0, 1'($urandom));
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (char_pairs.size() != 0 || item_valid || awaited_scores.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d character pair transactions sent, %0d word pairs scored", sent_items,
			scored_pairs);
		$display("%0d scored similar, %0d with a cut word, %0d results checked, %0d wrong",
			similar_pairs, cut_pairs, checked, mismatch_count);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
